[hdl/assert_macros.svh]
// assertion macros used by the port-level checker file, mtkte_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/mtkte_pkg.sv]
// shared types, constants and letter tables of the multi-tap text entry block
// no dependencies
package mtkte_pkg;

   // message store geometry
   localparam int MSG_CAPACITY = 32;
   localparam int ADDR_W       = $clog2(MSG_CAPACITY);
   localparam int CNT_W        = $clog2(MSG_CAPACITY + 1);

   // result word field widths
   localparam int KIND_W = 3;
   localparam int CHAR_W = 8;
   localparam int POS_W  = 5;
   localparam int LEN_W  = 6;

   // longest readout and its count width
   localparam int MAX_OUT  = 32;
   localparam int STRM_W   = 6;
   localparam int CMP_W    = (CNT_W > STRM_W) ? CNT_W : STRM_W;

   // key characters
   localparam logic [CHAR_W-1:0] KEY_STAR = 8'h2A;
   localparam logic [CHAR_W-1:0] KEY_HASH = 8'h23;
   localparam logic [CHAR_W-1:0] KEY_ONE  = 8'h31;
   localparam logic [CHAR_W-1:0] KEY_SIX  = 8'h36;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      EV_LETTER   = 3'd0,
      EV_HASH     = 3'd1,
      EV_INVALID  = 3'd2,
      EV_CHAR     = 3'd3,
      EV_EMPTY    = 3'd4,
      EV_INACTIVE = 3'd5
   } event_kind_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   // letters on a key group
   function automatic logic [2:0] group_size(input logic [2:0] grp);
      unique case (grp)
         3'd3, 3'd5: group_size = 3'd4;
         default:    group_size = 3'd3;
      endcase
   endfunction

   // letter of a key group at a tap position
   function automatic logic [CHAR_W-1:0] group_letter(input logic [2:0] grp,
                                                      input logic [1:0] tap);
      logic [CHAR_W-1:0] base;
      unique case (grp)
         3'd0:    base = 8'h61; // a
         3'd1:    base = 8'h64; // d
         3'd2:    base = 8'h67; // g
         3'd3:    base = 8'h70; // p
         3'd4:    base = 8'h74; // t
         3'd5:    base = 8'h77; // w
         default: base = 8'h00;
      endcase
      group_letter = base + {6'd0, tap};
   endfunction

endpackage

[hdl/mtkte_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mtkte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/multitap_keypad_text_entry_top.sv]
// top level of the multi-tap keypad text entry block
// depends on mtkte_pkg and mtkte_ram
//
// usage
//   req channel carries one raw key character per word (req_key_code).
//   rsp channel carries result words: kind, letter, slot, message length,
//   end cause and a last-of-run flag on the final word of each key.
//   keys 1..6 show a letter and write it into the pending message slot,
//   # commits it unless only the last slot is left, a second # in a row
//   or * ends entry and reads the message out, any other key reports
//   invalid; after the end every key reports inactive.
// flow
//   a key with one result word shows it in the cycle after acceptance, and the
//   next key can be taken in the following cycle (one key per cycle) while
//   the result side does not stall. an ending key reads the message ram: each
//   char takes a ram read in ST_READ, then an output load in ST_SEND once the
//   output register is free, before the next char is read; up to 32 chars, and no key is taken during the readout.
// reset
//   synchronous, active high; clears the message length, tap state and
//   entry-ended flag. the ram contents are not cleared and are only read
//   at slots written earlier.
// stall
//   a stalled result word holds in the output register; a new key is taken
//   only when that register is empty or being emptied in the same cycle.
module multitap_keypad_text_entry_top
   import mtkte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_key_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_event_kind,
   output logic [CHAR_W-1:0] rsp_letter,
   output logic [POS_W-1:0]  rsp_position,
   output logic [LEN_W-1:0]  rsp_message_length,
   output logic              rsp_end_cause,
   output logic              rsp_last_of_run
);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [2:0]        last_key_ff, last_key_in;
   logic [1:0]        tap_ff, tap_in;
   logic              prev_hash_ff, prev_hash_in;
   logic              ended_ff, ended_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [STRM_W-1:0] strm_n_ff, strm_n_in;
   logic              cause_ff, cause_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   event_kind_type    kind_ff, kind_in;
   logic [CHAR_W-1:0] letter_ff, letter_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              end_cause_ff, end_cause_in;
   logic              last_ff, last_in;

   // ram ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;

   // key decode and helpers
   logic              out_free;
   logic              accept;
   logic [CNT_W-1:0]  cur_len;
   logic              is_letter_key;
   logic [2:0]        grp;
   logic [2:0]        grp_size;
   logic [2:0]        tap_inc;
   logic [1:0]        tap_next;
   logic              same_key;
   logic [CHAR_W-1:0] key_letter;
   logic              do_finish;
   logic              finish_cause;
   logic [STRM_W-1:0] finish_n;
   logic              strm_last;

   mtkte_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(MSG_CAPACITY)
   ) u_msg_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // letter selection for keys 1..6
   assign cur_len       = count_ff + CNT_W'(pend_ff);
   assign is_letter_key = (req_key_code >= KEY_ONE) && (req_key_code <= KEY_SIX);
   assign grp           = 3'(req_key_code - KEY_ONE);
   assign grp_size      = group_size(grp);
   assign same_key      = (last_key_ff == (grp + 3'd1));
   assign tap_inc       = {1'b0, tap_ff} + 3'd1;
   assign tap_next      = !same_key ? 2'd0 : ((tap_inc == grp_size) ? 2'd0 : tap_inc[1:0]);
   assign key_letter    = group_letter(grp, tap_next);

   // end of entry: star, or a hash right after a hash
   assign do_finish    = (req_key_code == KEY_STAR) ||
                         ((req_key_code == KEY_HASH) && prev_hash_ff);
   assign finish_cause = (req_key_code != KEY_STAR);
   assign finish_n     = (CMP_W'(cur_len) > CMP_W'(MAX_OUT)) ? STRM_W'(MAX_OUT)
                                                             : STRM_W'(cur_len);
   assign strm_last    = (({1'b0, idx_ff} + STRM_W'(1)) == strm_n_ff);

   // sequencer and key handling
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      last_key_in  = last_key_ff;
      tap_in       = tap_ff;
      prev_hash_in = prev_hash_ff;
      ended_in     = ended_ff;
      idx_in       = idx_ff;
      strm_n_in    = strm_n_ff;
      cause_in     = cause_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      letter_in    = letter_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      end_cause_in = end_cause_ff;
      last_in      = last_ff;

      wr_en   = 1'b0;
      wr_addr = ADDR_W'(count_ff);
      wr_data = key_letter;
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // defaults for a single result word
               out_valid_in = 1'b1;
               letter_in    = '0;
               pos_in       = '0;
               len_in       = LEN_W'(cur_len);
               end_cause_in = 1'b0;
               last_in      = 1'b1;
               priority if (ended_ff) begin
                  kind_in = EV_INACTIVE;
               end else if (do_finish) begin
                  ended_in     = 1'b1;
                  cause_in     = finish_cause;
                  end_cause_in = finish_cause;
                  if (cur_len == '0) begin
                     kind_in = EV_EMPTY;
                  end else begin
                     out_valid_in = 1'b0;
                     idx_in       = '0;
                     strm_n_in    = finish_n;
                     state_in     = ST_READ;
                  end
               end else if (req_key_code == KEY_HASH) begin
                  logic commit;
                  commit       = pend_ff && (count_ff < CNT_W'(MSG_CAPACITY - 1));
                  count_in     = count_ff + CNT_W'(commit);
                  pend_in      = pend_ff && !commit;
                  last_key_in  = 3'd0;
                  tap_in       = 2'd0;
                  prev_hash_in = 1'b1;
                  kind_in      = EV_HASH;
                  pos_in       = POS_W'(count_in);
                  len_in       = LEN_W'(count_in + CNT_W'(pend_in));
               end else if (is_letter_key) begin
                  prev_hash_in = 1'b0;
                  last_key_in  = grp + 3'd1;
                  tap_in       = tap_next;
                  pend_in      = 1'b1;
                  wr_en        = 1'b1;
                  kind_in      = EV_LETTER;
                  letter_in    = key_letter;
                  pos_in       = POS_W'(count_ff);
                  len_in       = LEN_W'(count_ff + CNT_W'(1));
               end else begin
                  prev_hash_in = 1'b0;
                  kind_in      = EV_INVALID;
                  pos_in       = POS_W'(count_ff);
               end
            end
         end
         ST_READ: begin
            // fetch the next message char
            rd_en    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            // present the fetched char once the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = EV_CHAR;
               letter_in    = rd_data;
               pos_in       = idx_ff;
               len_in       = LEN_W'(cur_len);
               end_cause_in = cause_ff;
               last_in      = strm_last;
               idx_in       = idx_ff + POS_W'(1);
               state_in     = strm_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         last_key_ff  <= 3'd0;
         tap_ff       <= 2'd0;
         prev_hash_ff <= 1'b0;
         ended_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         last_key_ff  <= last_key_in;
         tap_ff       <= tap_in;
         prev_hash_ff <= prev_hash_in;
         ended_ff     <= ended_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // readout counters and output word payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      strm_n_ff    <= strm_n_in;
      cause_ff     <= cause_in;
      kind_ff      <= kind_in;
      letter_ff    <= letter_in;
      pos_ff       <= pos_in;
      len_ff       <= len_in;
      end_cause_ff <= end_cause_in;
      last_ff      <= last_in;
   end

   // result port
   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_letter         = letter_ff;
   assign rsp_position       = pos_ff;
   assign rsp_message_length = len_ff;
   assign rsp_end_cause      = end_cause_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

[hdl/mtkte_checker.sv]
// port-level checks of the multi-tap text entry block, bound to the top level
// depends on mtkte_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtkte_checker
   import mtkte_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [KIND_W-1:0] rsp_event_kind,
   input logic [CHAR_W-1:0] rsp_letter,
   input logic [POS_W-1:0]  rsp_position,
   input logic              rsp_end_cause,
   input logic              rsp_last_of_run
);

   logic is_text;
   logic is_end;
   logic rsp_hold;

   assign is_text  = (rsp_event_kind == EV_LETTER) || (rsp_event_kind == EV_CHAR);
   assign is_end   = (rsp_event_kind == EV_CHAR) || (rsp_event_kind == EV_EMPTY);
   assign rsp_hold = rsp_valid && rsp_stall;

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold,
      rsp_valid && $stable(rsp_event_kind) && $stable(rsp_letter) && $stable(rsp_position))

   // only message chars may leave a run open
   `ASSERT_IMPLY(a_single_last, clock, reset,
      rsp_valid && (rsp_event_kind != EV_CHAR), rsp_last_of_run)

   // letter field is zero on words that carry no letter
   `ASSERT_IMPLY(a_letter_zero, clock, reset, rsp_valid && !is_text, rsp_letter == '0)

   // end cause is set only on end words
   `ASSERT_IMPLY(a_cause_zero, clock, reset, rsp_valid && !is_end, !rsp_end_cause)

   // no key is taken while a readout run is still open
   `ASSERT_IMPLY(a_no_take_in_run, clock, reset,
      rsp_valid && (rsp_event_kind == EV_CHAR) && !rsp_last_of_run, req_stall)

endmodule

bind multitap_keypad_text_entry_top mtkte_checker u_mtkte_checker (.*);

[sim/mtkte_entry_checker.sv]
// checker for the multi-tap keypad text entry block: tracks the typed text,
// predicts the result words of every accepted key and compares them in order
// depends on mtkte_pkg
`timescale 1ns / 1ps

module mtkte_entry_checker
   import mtkte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CHAR_W-1:0] req_key_code,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [KIND_W-1:0] rsp_event_kind,
   input  logic [CHAR_W-1:0] rsp_letter,
   input  logic [POS_W-1:0]  rsp_position,
   input  logic [LEN_W-1:0]  rsp_message_length,
   input  logic              rsp_end_cause,
   input  logic              rsp_last_of_run,
   output int unsigned       mismatch_count,
   output int unsigned       words_owed
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      event_kind_type    kind;
      logic [CHAR_W-1:0] letter;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      logic              cause;
      logic              last;
   } result_word_type;

   // result words still to come, oldest first
   result_word_type owed_words[$];

   // own copy of the entry state
   logic [CHAR_W-1:0] typed_text [MSG_CAPACITY];
   int unsigned       committed;
   bit                letter_open;
   int unsigned       prev_group;
   int unsigned       tap;
   bit                hash_seen;
   bit                entry_done;
   int unsigned       errors = 0;

   function automatic int unsigned text_length();
      return committed + (letter_open ? 1 : 0);
   endfunction

   function automatic void owe(event_kind_type k, logic [CHAR_W-1:0] l, int unsigned p,
                               int unsigned n, bit c, bit last);
      result_word_type w;
      w.kind   = k;
      w.letter = l;
      w.pos    = POS_W'(p);
      w.len    = LEN_W'(n);
      w.cause  = c;
      w.last   = last;
      owed_words.push_back(w);
   endfunction

   // letters of a key group, first letter in the top byte, zero pad on 3-letter keys
   function automatic logic [31:0] key_row(int unsigned grp);
      unique case (grp)
         0:       key_row = {"abc", 8'h00};
         1:       key_row = {"def", 8'h00};
         2:       key_row = {"ghi", 8'h00};
         3:       key_row = "pqrs";
         4:       key_row = {"tuv", 8'h00};
         default: key_row = "wxyz";
      endcase
   endfunction

   // end of entry: read out the text, or one empty word
   function automatic void close_entry(bit cause);
      int unsigned n_all;
      int unsigned n_out;
      n_all = text_length();
      n_out = (n_all > MAX_OUT) ? MAX_OUT : n_all;
      entry_done = 1'b1;
      if (n_out == 0)
         owe(EV_EMPTY, '0, 0, n_all, cause, 1'b1);
      else
         for (int unsigned i = 0; i < n_out; i++)
            owe(EV_CHAR, typed_text[(i < MSG_CAPACITY) ? i : MSG_CAPACITY - 1], i, n_all,
                cause, (i + 1 == n_out));
   endfunction

   // expected words for one accepted key
   function automatic void take_key(logic [CHAR_W-1:0] k);
      int unsigned grp;
      int unsigned slot;
      logic [31:0] row;
      if (entry_done) begin
         owe(EV_INACTIVE, '0, 0, text_length(), 1'b0, 1'b1);
      end else if (k == KEY_STAR) begin
         close_entry(1'b0);
      end else if (k == KEY_HASH) begin
         if (hash_seen) begin
            close_entry(1'b1);
         end else begin
            // commit is dropped once only the last slot is left
            if (letter_open && committed < MSG_CAPACITY - 1) begin
               committed++;
               letter_open = 1'b0;
            end
            prev_group = 0;
            tap        = 0;
            hash_seen  = 1'b1;
            owe(EV_HASH, '0, committed, text_length(), 1'b0, 1'b1);
         end
      end else begin
         hash_seen = 1'b0;
         if (k >= KEY_ONE && k <= KEY_SIX) begin
            grp  = 32'(k - KEY_ONE);
            row  = key_row(grp);
            slot = (committed < MSG_CAPACITY) ? committed : MSG_CAPACITY - 1;
            if (grp + 1 == prev_group) begin
               tap = (tap + 1) % ((row[7:0] == 8'h00) ? 3 : 4);
            end else begin
               tap        = 0;
               prev_group = grp + 1;
            end
            typed_text[slot] = row[31 - 8 * tap -: 8];
            letter_open      = 1'b1;
            owe(EV_LETTER, typed_text[slot], slot, text_length(), 1'b0, 1'b1);
         end else begin
            owe(EV_INVALID, '0, committed, text_length(), 1'b0, 1'b1);
         end
      end
   endfunction

   // watch both channels at the clock edge
   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         owed_words.delete();
         committed   = 0;
         letter_open = 1'b0;
         prev_group  = 0;
         tap         = 0;
         hash_seen   = 1'b0;
         entry_done  = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            take_key(req_key_code);
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected result word kind %0d letter %h pos %0d len %0d",
                           $realtime, rsp_event_kind, rsp_letter, rsp_position,
                           rsp_message_length);
            end else begin
               want = owed_words.pop_front();
               if (want.kind != rsp_event_kind || want.letter != rsp_letter ||
                   want.pos != rsp_position || want.len != rsp_message_length ||
                   want.cause != rsp_end_cause || want.last != rsp_last_of_run) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"%0t: result word mismatch, expected kind %0d letter %h ",
                               "pos %0d len %0d cause %0d last %0d, got kind %0d ",
                               "letter %h pos %0d len %0d cause %0d last %0d"},
                              $realtime, want.kind, want.letter, want.pos, want.len,
                              want.cause, want.last, rsp_event_kind, rsp_letter,
                              rsp_position, rsp_message_length, rsp_end_cause,
                              rsp_last_of_run);
               end
            end
         end
      end
      mismatch_count = errors;
      words_owed     = owed_words.size();
   end

endmodule

[sim/tb_multitap_keypad_text_entry_top.sv]
// testbench top for the multi-tap keypad text entry block: drives keys with
// random gaps and result stalls, and gives the verdict
// depends on mtkte_pkg, multitap_keypad_text_entry_top and mtkte_entry_checker
`timescale 1ns / 1ps

module tb_multitap_keypad_text_entry_top;
   import mtkte_pkg::*;

   localparam int IDLE_PCT     = 38;
   localparam int RANDOM_KEYS  = 350;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int AFTER_END    = 20;

   logic              clock;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic [CHAR_W-1:0] req_key_code = '0;
   logic              rsp_stall    = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [KIND_W-1:0] rsp_event_kind;
   logic [CHAR_W-1:0] rsp_letter;
   logic [POS_W-1:0]  rsp_position;
   logic [LEN_W-1:0]  rsp_message_length;
   logic              rsp_end_cause;
   logic              rsp_last_of_run;

   int unsigned       mismatches;
   int unsigned       owed;
   int unsigned       quiet_cycles = 0;
   bit                calm         = 1'b0;
   logic [CHAR_W-1:0] last_sent    = '0;

   multitap_keypad_text_entry_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_letter         (rsp_letter),
      .rsp_position       (rsp_position),
      .rsp_message_length (rsp_message_length),
      .rsp_end_cause      (rsp_end_cause),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   mtkte_entry_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_letter         (rsp_letter),
      .rsp_position       (rsp_position),
      .rsp_message_length (rsp_message_length),
      .rsp_end_cause      (rsp_end_cause),
      .rsp_last_of_run    (rsp_last_of_run),
      .mismatch_count     (mismatches),
      .words_owed         (owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side stalls at random outside the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // watchdog on cycles where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("tb_multitap_keypad_text_entry_top: done, errors");
            $finish;
         end
      end
   end

   // offer one key word, with a random gap first; returns at the falling edge
   task automatic send_key(input logic [CHAR_W-1:0] k);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= k;
      do
         @(posedge clock);
      while (req_stall);
      last_sent = k;
      @(negedge clock);
   endtask

   initial begin
      logic [CHAR_W-1:0] opening [25];
      logic [CHAR_W-1:0] k;
      int unsigned       pick;

      // cycling on one key, wrap on 3 and 4 letter keys, key changes, commits,
      // letter after hash, invalid keys at the edges, hash with nothing pending,
      // invalid key between taps of the same key
      opening = '{KEY_ONE, KEY_ONE, KEY_ONE, KEY_ONE,
                  KEY_ONE + 8'd3, KEY_ONE + 8'd3, KEY_ONE + 8'd3, KEY_ONE + 8'd3,
                  KEY_ONE + 8'd3, KEY_SIX, KEY_ONE + 8'd1, KEY_HASH, KEY_ONE + 8'd1,
                  KEY_ONE - 8'd1, 8'hFF, 8'h00, KEY_SIX + 8'd1, KEY_HASH, 8'h40,
                  KEY_HASH, KEY_ONE + 8'd4, KEY_ONE + 8'd2, KEY_ONE + 8'd2, 8'h39,
                  KEY_ONE + 8'd2};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         send_key(opening[i]);

      // mostly letter taps and single commits, some invalid noise;
      // fills the store and keeps overwriting its last slot
      for (int n = 0; n < RANDOM_KEYS; n++) begin
         calm = (n >= 200 && n < 280);
         pick = $urandom_range(0, 99);
         if (pick < 85 && (pick < 62 || last_sent == KEY_HASH)) begin
            if (last_sent >= KEY_ONE && last_sent <= KEY_SIX && $urandom_range(0, 1))
               k = last_sent;
            else
               k = KEY_ONE + CHAR_W'($urandom_range(0, 5));
         end else if (pick < 85) begin
            k = KEY_HASH;
         end else begin
            do
               k = CHAR_W'($urandom_range(0, 255));
            while ((k >= KEY_ONE && k <= KEY_SIX) || k == KEY_STAR || k == KEY_HASH);
         end
         send_key(k);
      end
      calm = 1'b0;

      // end entry by star or by double hash
      if ($urandom_range(0, 1)) begin
         send_key(KEY_STAR);
      end else begin
         if (last_sent != KEY_HASH)
            send_key(KEY_HASH);
         send_key(KEY_HASH);
      end

      // keys after the end, any value
      send_key(KEY_ONE);
      send_key(KEY_HASH);
      send_key(KEY_STAR);
      for (int n = 0; n < AFTER_END; n++)
         send_key(CHAR_W'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      while (owed != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && owed == 0)
         $display("tb_multitap_keypad_text_entry_top: done, clean");
      else
         $display("tb_multitap_keypad_text_entry_top: done, errors");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/mtkte_pkg.sv
hdl/mtkte_ram.sv
hdl/multitap_keypad_text_entry_top.sv
hdl/mtkte_checker.sv
sim/mtkte_entry_checker.sv
sim/tb_multitap_keypad_text_entry_top.sv
